// ----- rtl/htbqa_pkg.sv -----
`default_nettype none
// Shared types and constants for the handle table byte quota allocator.
// No dependencies; imported by the top level module of the block.
package htbqa_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int SIZE_BITS   = 40;

	localparam int SIZE_W     = SIZE_BITS + 1;
	localparam int HANDLE_W   = 32;
	localparam int STATUS_W   = 3;
	localparam int LIVE_OUT_W = 5;
	localparam int IDX_W      = $clog2(MAX_ENTRIES);
	localparam int SCAN_W     = IDX_W + 1;
	localparam int LIVE_W     = $clog2(MAX_ENTRIES + 1);
	localparam int SLOT_W     = HANDLE_W + SIZE_W;

	localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(64'd268435456);

	// APB register map: 8 byte stride, one register
	localparam int PDATA_W = 64;
	localparam int PADDR_W = 4;
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_ZERO     = 3'd1,
		ST_NOCAP    = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

endpackage
`default_nettype wire

// ----- rtl/htbqa_ram.sv -----
`default_nettype none
// Generic simple dual port RAM: one write port, one read port, registered read.
// No package dependency.
module htbqa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/handle_table_byte_quota_allocator.sv -----
`default_nettype none
// Top level of the handle table byte quota allocator: sequencer, shared adder,
// valid bits and APB capacity register. Uses htbqa_pkg and htbqa_ram.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------------------
//  request   | req_valid/req_ready | opcode, request_size, handle
//  response  | rsp_valid/rsp_ready | status, granted_handle, granted_size,
//            |                     | bytes_in_use, live_count
//  config    | APB psel/penable    | paddr, pwdata, prdata (64 bit)
//
// A zero-size allocate goes straight to done; any other allocate checks capacity in
// S_CAP1 and S_CAP2, then scans for a free slot; a free scans for its handle. A
// capacity refusal, a full table or a miss goes to done without an update.
// The table is scanned one slot per cycle (valid bits for an allocate, the slot
// RAM read port for a free), then the update state runs if a slot was found.
// All size sums and capacity compares go through one shared 41-bit add/subtract unit.
// req_ready is high only while the sequencer is idle; a finished response sits
// in the output register while the next request is taken. If that register is
// still full when the next response is done, the sequencer waits in its last state.
// Reset clears the valid bits at once; there is no clearing pass.
module handle_table_byte_quota_allocator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire logic                               opcode,
	input  wire logic [htbqa_pkg::SIZE_W-1:0]       request_size,
	input  wire logic [htbqa_pkg::HANDLE_W-1:0]     handle,
	// response
	output logic                                    rsp_valid,
	input  wire logic                               rsp_ready,
	output logic      [htbqa_pkg::STATUS_W-1:0]     status,
	output logic      [htbqa_pkg::HANDLE_W-1:0]     granted_handle,
	output logic      [htbqa_pkg::SIZE_W-1:0]       granted_size,
	output logic      [htbqa_pkg::SIZE_W-1:0]       bytes_in_use,
	output logic      [htbqa_pkg::LIVE_OUT_W-1:0]   live_count,
	// configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [htbqa_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [htbqa_pkg::PDATA_W-1:0]      pwdata,
	output logic      [htbqa_pkg::PDATA_W-1:0]      prdata,
	output logic                                    pready
);
	import htbqa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CAP1,
		S_CAP2,
		S_FIND_FREE,
		S_FIND_HANDLE,
		S_UPDATE,
		S_DONE
	} state_t;

	state_t                 state_q;
	op_t                    op_q;
	logic [SIZE_W-1:0]      rsize_q;
	logic [HANDLE_W-1:0]    handle_q;
	logic [SIZE_W-1:0]      cap_q;
	logic [SIZE_W-1:0]      used_q;
	logic [LIVE_W-1:0]      live_q;
	logic [HANDLE_W-1:0]    next_handle_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [SIZE_W-1:0]      diff_q;
	logic                   over_q;
	logic [SCAN_W-1:0]      scan_q;
	logic                   pend_q;
	logic [IDX_W-1:0]       pend_idx_q;
	logic [IDX_W-1:0]       slot_q;
	status_t                status_q;
	logic [HANDLE_W-1:0]    ghandle_q;
	logic [SIZE_W-1:0]      gsize_q;

	logic                   rsp_valid_q;
	status_t                rsp_status_q;
	logic [HANDLE_W-1:0]    rsp_handle_q;
	logic [SIZE_W-1:0]      rsp_size_q;
	logic [SIZE_W-1:0]      rsp_used_q;
	logic [LIVE_OUT_W-1:0]  rsp_live_q;

	// shared add/subtract unit
	logic [SIZE_W-1:0]      alu_a;
	logic [SIZE_W-1:0]      alu_b;
	logic                   alu_sub;
	logic [SIZE_W:0]        alu_y;
	logic                   alu_borrow;

	// slot RAM
	logic                   ram_we;
	logic [SLOT_W-1:0]      ram_wdata;
	logic [IDX_W-1:0]       ram_raddr;
	logic [SLOT_W-1:0]      ram_rdata;
	logic [HANDLE_W-1:0]    rd_handle;
	logic [SIZE_W-1:0]      rd_size;

	logic                   rsp_load;
	logic                   scan_last;
	logic                   scan_more;
	logic                   hit;
	logic [HANDLE_W-1:0]    nh_inc;
	logic [31:0]            live_ext;
	logic                   cfg_wr;

	always_comb begin
		alu_a   = used_q;
		alu_b   = rsize_q;
		alu_sub = 1'b0;
		unique case (state_q)
			S_CAP1: begin
				alu_a   = cap_q;
				alu_b   = used_q;
				alu_sub = 1'b1;
			end
			S_CAP2: begin
				alu_a   = diff_q;
				alu_b   = rsize_q;
				alu_sub = 1'b1;
			end
			S_UPDATE: begin
				alu_a   = used_q;
				alu_b   = (op_q == OP_FREE) ? gsize_q : rsize_q;
				alu_sub = (op_q == OP_FREE);
			end
			default: begin
				alu_a   = used_q;
				alu_b   = rsize_q;
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_y      = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                            : ({1'b0, alu_a} + {1'b0, alu_b});
	assign alu_borrow = alu_sub & alu_y[SIZE_W];

	assign ram_we    = (state_q == S_UPDATE) && (op_q == OP_ALLOC);
	assign ram_wdata = {next_handle_q, rsize_q};
	assign ram_raddr = scan_q[IDX_W-1:0];
	assign rd_handle = ram_rdata[SLOT_W-1:SIZE_W];
	assign rd_size   = ram_rdata[SIZE_W-1:0];

	htbqa_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(MAX_ENTRIES)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign scan_last = (scan_q == SCAN_W'(MAX_ENTRIES - 1));
	assign scan_more = (scan_q < SCAN_W'(MAX_ENTRIES));
	// read data belongs to the slot issued last cycle
	assign hit       = pend_q && valid_q[pend_idx_q] && (rd_handle == handle_q);
	assign nh_inc    = next_handle_q + HANDLE_W'(1);
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	assign live_ext  = 32'(live_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_ALLOC;
			rsize_q       <= '0;
			handle_q      <= '0;
			used_q        <= '0;
			live_q        <= '0;
			next_handle_q <= HANDLE_W'(1);
			valid_q       <= '0;
			diff_q        <= '0;
			over_q        <= 1'b0;
			scan_q        <= '0;
			pend_q        <= 1'b0;
			pend_idx_q    <= '0;
			slot_q        <= '0;
			status_q      <= ST_OK;
			ghandle_q     <= '0;
			gsize_q       <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_status_q  <= ST_OK;
			rsp_handle_q  <= '0;
			rsp_size_q    <= '0;
			rsp_used_q    <= '0;
			rsp_live_q    <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q      <= op_t'(opcode);
						rsize_q   <= request_size;
						handle_q  <= handle;
						status_q  <= ST_OK;
						ghandle_q <= '0;
						gsize_q   <= '0;
						scan_q    <= '0;
						pend_q    <= 1'b0;
						if (op_t'(opcode) == OP_FREE) begin
							state_q <= S_FIND_HANDLE;
						end else if (request_size == '0) begin
							status_q <= ST_ZERO;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_CAP1;
						end
					end
				end
				S_CAP1: begin
					// capacity minus use; borrow means use already exceeds capacity
					diff_q  <= alu_y[SIZE_W-1:0];
					over_q  <= alu_borrow;
					state_q <= S_CAP2;
				end
				S_CAP2: begin
					if (over_q || alu_borrow) begin
						status_q <= ST_NOCAP;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_FIND_FREE;
					end
				end
				S_FIND_FREE: begin
					if (!valid_q[scan_q[IDX_W-1:0]]) begin
						slot_q  <= scan_q[IDX_W-1:0];
						state_q <= S_UPDATE;
					end else if (scan_last) begin
						status_q <= ST_FULL;
						state_q  <= S_DONE;
					end else begin
						scan_q <= scan_q + SCAN_W'(1);
					end
				end
				S_FIND_HANDLE: begin
					if (scan_more) begin
						pend_q     <= 1'b1;
						pend_idx_q <= scan_q[IDX_W-1:0];
						scan_q     <= scan_q + SCAN_W'(1);
					end else begin
						pend_q <= 1'b0;
					end
					if (hit) begin
						slot_q  <= pend_idx_q;
						gsize_q <= rd_size;
						state_q <= S_UPDATE;
					end else if (!pend_q && !scan_more) begin
						status_q <= ST_NOTFOUND;
						state_q  <= S_DONE;
					end
				end
				S_UPDATE: begin
					used_q <= alu_y[SIZE_W-1:0];
					if (op_q == OP_FREE) begin
						valid_q[slot_q] <= 1'b0;
						live_q          <= live_q - LIVE_W'(1);
					end else begin
						valid_q[slot_q] <= 1'b1;
						live_q          <= live_q + LIVE_W'(1);
						ghandle_q       <= next_handle_q;
						gsize_q         <= rsize_q;
						next_handle_q   <= (nh_inc == '0) ? HANDLE_W'(1) : nh_inc;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_status_q <= status_q;
						rsp_handle_q <= ghandle_q;
						rsp_size_q   <= gsize_q;
						rsp_used_q   <= used_q;
						rsp_live_q   <= live_ext[LIVE_OUT_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready      = (state_q == S_IDLE);
	assign rsp_valid      = rsp_valid_q;
	assign status         = rsp_status_q;
	assign granted_handle = rsp_handle_q;
	assign granted_size   = rsp_size_q;
	assign bytes_in_use   = rsp_used_q;
	assign live_count     = rsp_live_q;

	// APB capacity register
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr && (paddr[PADDR_W-1] == REG_CAPACITY)) begin
			cap_q <= pwdata[SIZE_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

endmodule
`default_nettype wire
